// ----- sv/afd_pkg.sv -----
// shared types and constants for the adpcm frame decoder
// no dependencies; used by the front, queue and back modules and the top level
package afd_pkg;

  localparam int DATA_W   = 8;
  localparam int IDX_W    = 5;
  localparam int COEF_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 4;
  localparam int PAIR_W   = 4;
  localparam int REM_W    = 3;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 34;
  localparam int COEF_PAIRS = 16;

  localparam logic MODE_4BIT = 1'b0;
  localparam logic MODE_2BIT = 1'b1;

  localparam logic [POS_W-1:0] POS_HEADER   = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST    = 4'd1;
  localparam logic [POS_W-1:0] FINAL_POS_4B = 4'd8;
  localparam logic [POS_W-1:0] FINAL_POS_2B = 4'd4;

  localparam logic [REM_W-1:0] SAMPLES_4B = 3'd2;
  localparam logic [REM_W-1:0] SAMPLES_2B = 3'd4;

  localparam int SHIFT_4B   = 11;
  localparam int SHIFT_2B   = 13;
  localparam int FRAC_SHIFT = 11;

  localparam logic [PAIR_W-1:0] SCALE_NEG = 4'hf;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t SAT_MAX = 34'sd32767;
  localparam acc_t SAT_MIN = -34'sd32768;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DATA   = 2'd2
  } kind_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    kind_t                     kind;
    logic [DATA_W-1:0]         data_byte;
    logic [IDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic                      mode;
    logic                      frame_done;
  } entry_t;

endpackage

// ----- sv/afd_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module afd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/afd_front.sv -----
// front end: accepts stream items and tags them as load, header or data
// depends on afd_pkg
module afd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [afd_pkg::DATA_W-1:0]        in_data_byte,
  input  logic [afd_pkg::IDX_W-1:0]         in_coef_index,
  input  logic signed [afd_pkg::COEF_W-1:0] in_coef_value,
  input  logic                              code_mode,
  input  logic                              q_full,
  output logic                              push,
  output afd_pkg::entry_t                   entry
);

  logic [afd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [afd_pkg::POS_W-1:0] final_pos;
  logic                      done;

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign final_pos = (code_mode == afd_pkg::MODE_2BIT) ? afd_pkg::FINAL_POS_2B
                                                       : afd_pkg::FINAL_POS_4B;
  // a byte at or past the final position closes the frame
  assign done      = (pos_r >= final_pos);

  always_comb begin
    entry.data_byte  = in_data_byte;
    entry.coef_index = in_coef_index;
    entry.coef_value = in_coef_value;
    entry.mode       = code_mode;
    entry.frame_done = done;
    pos_nxt          = pos_r;
    if (in_command) begin
      entry.kind = afd_pkg::KIND_LOAD;
    end else if (pos_r == afd_pkg::POS_HEADER) begin
      entry.kind = afd_pkg::KIND_HEADER;
      pos_nxt    = afd_pkg::POS_FIRST;
    end else begin
      entry.kind = afd_pkg::KIND_DATA;
      pos_nxt    = done ? afd_pkg::POS_HEADER : pos_r + afd_pkg::POS_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= afd_pkg::POS_HEADER;
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- sv/afd_queue.sv -----
// short fifo of classified items between front and back
// depends on afd_pkg
module afd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  afd_pkg::entry_t wr_entry,
  input  logic            pop,
  output afd_pkg::entry_t rd_entry,
  output logic            full,
  output logic            empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  afd_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ----- sv/afd_back.sv -----
// back end: coefficient table, predictor loop, history and result register
// depends on afd_pkg and afd_ram
module afd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  afd_pkg::entry_t                     head,
  input  logic                                q_empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [afd_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_last,
  output logic                                out_frame_end
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_SUM   = 4'b1000
  } state_t;

  localparam int AW = $clog2(afd_pkg::COEF_PAIRS);

  state_t state_r, state_nxt;

  logic [afd_pkg::PAIR_W-1:0]          scale_r, pair_r;
  logic [afd_pkg::DATA_W-1:0]          byte_r;
  logic                                mode_r, done_r;
  logic [afd_pkg::REM_W-1:0]           remain_r;
  logic signed [afd_pkg::SAMPLE_W-1:0] hist_last_r, hist_prev_r;
  logic signed [afd_pkg::PROD_W-1:0]   p0_r, p1_r;
  afd_pkg::acc_t                       dterm_r;
  logic                                out_valid_r, out_last_r, out_frame_end_r;
  logic signed [afd_pkg::SAMPLE_W-1:0] out_sample_r;

  logic                                load_we, even_we, odd_we;
  logic signed [afd_pkg::COEF_W-1:0]   c0, c1;
  logic signed [afd_pkg::SAMPLE_W-1:0] code_scaled;
  afd_pkg::acc_t                       code_ext, dterm, acc, shifted;
  logic signed [afd_pkg::SAMPLE_W-1:0] sat;
  logic                                out_free, out_load, last_sample;

  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign load_we  = pop && (head.kind == afd_pkg::KIND_LOAD);
  assign even_we  = load_we && !head.coef_index[0];
  assign odd_we   = load_we && head.coef_index[0];

  // even slots hold c0 of each pair, odd slots c1
  afd_ram #(.WIDTH(afd_pkg::COEF_W), .DEPTH(afd_pkg::COEF_PAIRS)) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (head.coef_index[afd_pkg::IDX_W-1:1]),
    .wdata (head.coef_value),
    .raddr (pair_r[AW-1:0]),
    .rdata (c0)
  );

  afd_ram #(.WIDTH(afd_pkg::COEF_W), .DEPTH(afd_pkg::COEF_PAIRS)) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (head.coef_index[afd_pkg::IDX_W-1:1]),
    .wdata (head.coef_value),
    .raddr (pair_r[AW-1:0]),
    .rdata (c1)
  );

  // scaled code and delta term: delta is a power of two, so this is a shift, negated when the scale is SCALE_NEG
  always_comb begin
    if (mode_r == afd_pkg::MODE_2BIT) begin
      code_scaled = afd_pkg::SAMPLE_W'(signed'(byte_r[7:6])) <<< afd_pkg::SHIFT_2B;
    end else begin
      code_scaled = afd_pkg::SAMPLE_W'(signed'(byte_r[7:4])) <<< afd_pkg::SHIFT_4B;
    end
    code_ext = afd_pkg::acc_t'(code_scaled);
    if (scale_r == afd_pkg::SCALE_NEG) begin
      dterm = -(code_ext <<< afd_pkg::SCALE_NEG);
    end else begin
      dterm = code_ext <<< scale_r;
    end
  end

  always_comb begin
    acc     = afd_pkg::acc_t'(p0_r) + afd_pkg::acc_t'(p1_r) + dterm_r;
    shifted = acc >>> afd_pkg::FRAC_SHIFT;
    if (shifted > afd_pkg::SAT_MAX) begin
      sat = afd_pkg::SAT_MAX[afd_pkg::SAMPLE_W-1:0];
    end else if (shifted < afd_pkg::SAT_MIN) begin
      sat = afd_pkg::SAT_MIN[afd_pkg::SAMPLE_W-1:0];
    end else begin
      sat = shifted[afd_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == ST_SUM) && out_free;
  assign last_sample = (remain_r == afd_pkg::REM_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && head.kind == afd_pkg::KIND_DATA) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM: begin
        if (out_load) begin
          state_nxt = last_sample ? ST_IDLE : ST_MUL;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= '0;
      pair_r      <= '0;
      hist_last_r <= '0;
      hist_prev_r <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && head.kind == afd_pkg::KIND_HEADER) begin
        scale_r <= head.data_byte[7:4];
        pair_r  <= head.data_byte[3:0];
      end
      if (pop && head.kind == afd_pkg::KIND_DATA) begin
        remain_r <= (head.mode == afd_pkg::MODE_2BIT) ? afd_pkg::SAMPLES_2B
                                                      : afd_pkg::SAMPLES_4B;
      end else if (out_load) begin
        remain_r <= remain_r - afd_pkg::REM_W'(1);
      end
      if (out_load) begin
        hist_prev_r <= hist_last_r;
        hist_last_r <= sat;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == afd_pkg::KIND_DATA) begin
      byte_r <= head.data_byte;
      mode_r <= head.mode;
      done_r <= head.frame_done;
    end else if (out_load) begin
      byte_r <= (mode_r == afd_pkg::MODE_2BIT) ? {byte_r[5:0], 2'b00}
                                               : {byte_r[3:0], 4'b0000};
    end
    if (state_r == ST_MUL) begin
      p0_r    <= hist_last_r * c0;
      p1_r    <= hist_prev_r * c1;
      dterm_r <= dterm;
    end
    if (out_load) begin
      out_sample_r    <= sat;
      out_last_r      <= last_sample;
      out_frame_end_r <= last_sample && done_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_last      = out_last_r;
  assign out_frame_end = out_frame_end_r;

  a_frame_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_last_r)
    else $error("frame end without last");

  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> remain_r != '0)
    else $error("sample count ran out inside a byte");

  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> hist_prev_r == $past(hist_last_r) && out_sample_r == hist_last_r)
    else $error("history not shifted with the sample");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM && out_load && last_sample |=> state_r == ST_IDLE && !$past(pop))
    else $error("byte finished without return to idle");

endmodule

// ----- sv/adpcm_frame_decoder.sv -----
// two-tap adpcm frame decoder: one header byte then packed 4-bit or 2-bit codes
// a data byte is dequeued and its coefficient pair read, then each of its samples (two in 4-bit mode,
// four in 2-bit mode) runs the multiply-then-sum loop through the history, the sum step waiting while
// the output is stalled; header and load items finish at dequeue; no new item is taken until a byte is done
// reset (rst_n low, synchronous) clears frame position, history, scale, pair, mode
// and the queue; the coefficient table is not cleared and must be loaded first
module adpcm_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                cfg_wr_en,
  input  logic                                cfg_code_mode,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [afd_pkg::DATA_W-1:0]          in_data_byte,
  input  logic [afd_pkg::IDX_W-1:0]           in_coef_index,
  input  logic signed [afd_pkg::COEF_W-1:0]   in_coef_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [afd_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_last,
  output logic                                out_frame_end
);

  // code mode register; the user must write it only while the block is idle, the block does not enforce this
  logic            mode_r;

  // front to queue
  logic            push;
  afd_pkg::entry_t wr_entry;

  // queue to back
  afd_pkg::entry_t head;
  logic            q_full, q_empty, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= afd_pkg::MODE_4BIT;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_code_mode;
    end
  end

  // front: tracks byte position within the frame and tags each transfer
  afd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .code_mode     (mode_r),
    .q_full        (q_full),
    .push          (push),
    .entry         (wr_entry)
  );

  // queue lets the front keep taking transfers while the back is busy
  afd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: coefficient loads, header latch and the predictor in stream order
  afd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_last      (out_last),
    .out_frame_end (out_frame_end)
  );

endmodule
